// ===== sv/bva_pkg.sv =====
// ----------------------------------------------------------------------------
// bva_pkg
// Shared constants and the operation code type of the bitvector ALU.
// ----------------------------------------------------------------------------
package bva_pkg;

    localparam int MAX_OPERAND_WIDTH = 32;

    localparam int OPCODE_BITS  = 4;
    localparam int OPERAND_BITS = 32;
    localparam int WIDTH_BITS   = 6;
    localparam int INDEX_BITS   = 5;
    localparam int RESULT_BITS  = 64;
    localparam int RWIDTH_BITS  = 7;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_EQ      = 4'd0,
        OP_EXTRACT = 4'd1,
        OP_LNOT    = 4'd2,
        OP_AND     = 4'd3,
        OP_OR      = 4'd4,
        OP_CONCAT  = 4'd5,
        OP_ULT     = 4'd6,
        OP_ULE     = 4'd7,
        OP_UGT     = 4'd8,
        OP_UGE     = 4'd9,
        OP_SLT     = 4'd10,
        OP_SLE     = 4'd11,
        OP_SGT     = 4'd12,
        OP_SGE     = 4'd13,
        OP_ADD     = 4'd14,
        OP_SUB     = 4'd15
    } opcode_t;

endpackage

// ===== sv/bitvector_alu_top.sv =====
// ----------------------------------------------------------------------------
// bitvector_alu_top
// Width-tagged bitvector operation unit, three register stages deep.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one request: opcode, two operands each with its bit width,
//   an extract range and a sum width. Operand bits above their width are
//   ignored; widths of 0 read as 1, widths above MAX_OPERAND_WIDTH clamp.
//   m_* returns one result per request: value, its width and bad_request,
//   which flags an extract range that is out of order or beyond width_a.
//   A request passes through the stage 1, stage 2 and stage 3 registers
//   in turn; m_valid is the stage 3 valid bit. While s_ready is high, one
//   request is taken per cycle: stage 1 clamps widths and masks operands,
//   stage 2 forms sign extensions, extract, concat, sum and difference,
//   stage 3 does the compares and the final select into the output register.
//   Reset clears all stage valid bits; the pipeline comes out empty.
//   When m_ready is low the stages hold and fill up behind the output
//   register; s_ready drops only once every stage holds a request.
// ----------------------------------------------------------------------------
module bitvector_alu_top #(
    parameter int MAX_OPERAND_WIDTH = bva_pkg::MAX_OPERAND_WIDTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [bva_pkg::OPCODE_BITS-1:0]  s_opcode,
    input  logic [bva_pkg::OPERAND_BITS-1:0] s_operand_a,
    input  logic [bva_pkg::WIDTH_BITS-1:0]   s_width_a,
    input  logic [bva_pkg::OPERAND_BITS-1:0] s_operand_b,
    input  logic [bva_pkg::WIDTH_BITS-1:0]   s_width_b,
    input  logic [bva_pkg::INDEX_BITS-1:0]   s_field_high,
    input  logic [bva_pkg::INDEX_BITS-1:0]   s_field_low,
    input  logic [bva_pkg::WIDTH_BITS-1:0]   s_sum_width,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [bva_pkg::RESULT_BITS-1:0]  m_result_value,
    output logic [bva_pkg::RWIDTH_BITS-1:0]  m_result_width,
    output logic                             m_bad_request
);

    localparam int W  = MAX_OPERAND_WIDTH;
    localparam int WW = $clog2(W + 1);
    localparam int CW = 2 * W;
    localparam int RW = $clog2(CW + 1);

    logic adv1, adv2, adv3;

    assign adv3    = !m_valid || m_ready;
    assign s_ready = adv1;

    // ---------------- stage 1: clamp widths, mask operands ----------------
    logic                 v1_reg;
    bva_pkg::opcode_t     op1_reg, op1_next;
    logic [W-1:0]         a1_reg, a1_next, b1_reg, b1_next;
    logic [WW-1:0]        wa1_reg, wa1_next, wb1_reg, wb1_next, ws1_reg, ws1_next;
    logic [bva_pkg::INDEX_BITS-1:0] hi1_reg, lo1_reg;

    function automatic logic [WW-1:0] fit_width(input logic [bva_pkg::WIDTH_BITS-1:0] w);
        logic [WW-1:0] r;
        if (w == '0) begin
            r = WW'(1);
        end else if (w > bva_pkg::WIDTH_BITS'(W)) begin
            r = WW'(W);
        end else begin
            r = WW'(w);
        end
        return r;
    endfunction

    function automatic logic [W-1:0] low_mask(input logic [WW-1:0] w);
        return ~({W{1'b1}} << w);
    endfunction

    always_comb begin
        op1_next = bva_pkg::opcode_t'(s_opcode);
        wa1_next = fit_width(s_width_a);
        wb1_next = fit_width(s_width_b);
        ws1_next = fit_width(s_sum_width);
        a1_next  = s_operand_a[W-1:0] & low_mask(wa1_next);
        b1_next  = s_operand_b[W-1:0] & low_mask(wb1_next);
    end

    assign adv1 = !v1_reg || adv2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv1) begin
            v1_reg <= s_valid;
        end
        if (adv1 && s_valid) begin
            op1_reg <= op1_next;
            a1_reg  <= a1_next;
            b1_reg  <= b1_next;
            wa1_reg <= wa1_next;
            wb1_reg <= wb1_next;
            ws1_reg <= ws1_next;
            hi1_reg <= s_field_high;
            lo1_reg <= s_field_low;
        end
    end

    // ---------------- stage 2: sign extend, extract, concat, add, sub -----
    logic                 v2_reg;
    bva_pkg::opcode_t     op2_reg;
    logic [W-1:0]         a2_reg, b2_reg;
    logic [W-1:0]         sa2_reg, sa2_next, sb2_reg, sb2_next;
    logic [W-1:0]         ext2_reg, ext2_next;
    logic [WW-1:0]        exw2_reg, exw2_next;
    logic                 bad2_reg, bad2_next;
    logic [CW-1:0]        cat2_reg, cat2_next;
    logic [W-1:0]         sum2_reg, sum2_next, dif2_reg, dif2_next;
    logic [WW-1:0]        wa2_reg, ws2_reg, wmax2_reg, wmax2_next;
    logic [RW-1:0]        wcat2_reg, wcat2_next;

    always_comb begin
        logic [W-1:0] sha, shb, shx;
        sha = a1_reg >> (wa1_reg - 1'b1);
        shb = b1_reg >> (wb1_reg - 1'b1);
        sa2_next = sha[0] ? (a1_reg | ~low_mask(wa1_reg)) : a1_reg;
        sb2_next = shb[0] ? (b1_reg | ~low_mask(wb1_reg)) : b1_reg;

        bad2_next = (hi1_reg < lo1_reg) ||
                    (bva_pkg::WIDTH_BITS'(hi1_reg) >= bva_pkg::WIDTH_BITS'(wa1_reg));
        exw2_next = bad2_next ? WW'(1) : (WW'(hi1_reg) - WW'(lo1_reg) + WW'(1));
        shx       = a1_reg >> lo1_reg;
        ext2_next = bad2_next ? '0 : (shx & low_mask(exw2_next));

        cat2_next  = (CW'(a1_reg) << wb1_reg) | CW'(b1_reg);
        wcat2_next = RW'(wa1_reg) + RW'(wb1_reg);
        wmax2_next = (wa1_reg > wb1_reg) ? wa1_reg : wb1_reg;

        sum2_next = (a1_reg + b1_reg) & low_mask(ws1_reg);
        dif2_next = (a1_reg - b1_reg) & low_mask(ws1_reg);
    end

    assign adv2 = !v2_reg || adv3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv2) begin
            v2_reg <= v1_reg;
        end
        if (adv2 && v1_reg) begin
            op2_reg   <= op1_reg;
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            sa2_reg   <= sa2_next;
            sb2_reg   <= sb2_next;
            ext2_reg  <= ext2_next;
            exw2_reg  <= exw2_next;
            bad2_reg  <= bad2_next;
            cat2_reg  <= cat2_next;
            wcat2_reg <= wcat2_next;
            wmax2_reg <= wmax2_next;
            wa2_reg   <= wa1_reg;
            ws2_reg   <= ws1_reg;
            sum2_reg  <= sum2_next;
            dif2_reg  <= dif2_next;
        end
    end

    // ---------------- stage 3: compare and select -------------------------
    logic                            v3_reg;
    logic [bva_pkg::RESULT_BITS-1:0] value_reg, value_next;
    logic [bva_pkg::RWIDTH_BITS-1:0] width_reg, width_next;
    logic                            bad_reg, bad_next;

    always_comb begin
        logic eq, ult, ugt, slt, sgt;
        eq  = (a2_reg == b2_reg);
        ult = (a2_reg < b2_reg);
        ugt = (b2_reg < a2_reg);
        slt = ($signed(sa2_reg) < $signed(sb2_reg));
        sgt = ($signed(sb2_reg) < $signed(sa2_reg));

        value_next = '0;
        width_next = bva_pkg::RWIDTH_BITS'(wmax2_reg);
        bad_next   = 1'b0;
        case (op2_reg)
            bva_pkg::OP_EQ:      value_next = bva_pkg::RESULT_BITS'(eq);
            bva_pkg::OP_EXTRACT: begin
                value_next = bva_pkg::RESULT_BITS'(ext2_reg);
                width_next = bva_pkg::RWIDTH_BITS'(exw2_reg);
                bad_next   = bad2_reg;
            end
            bva_pkg::OP_LNOT: begin
                value_next = bva_pkg::RESULT_BITS'(a2_reg == '0);
                width_next = bva_pkg::RWIDTH_BITS'(wa2_reg);
            end
            bva_pkg::OP_AND:     value_next = bva_pkg::RESULT_BITS'(a2_reg & b2_reg);
            bva_pkg::OP_OR:      value_next = bva_pkg::RESULT_BITS'(a2_reg | b2_reg);
            bva_pkg::OP_CONCAT: begin
                value_next = bva_pkg::RESULT_BITS'(cat2_reg);
                width_next = bva_pkg::RWIDTH_BITS'(wcat2_reg);
            end
            bva_pkg::OP_ULT:     value_next = bva_pkg::RESULT_BITS'(ult);
            bva_pkg::OP_ULE:     value_next = bva_pkg::RESULT_BITS'(!ugt);
            bva_pkg::OP_UGT:     value_next = bva_pkg::RESULT_BITS'(ugt);
            bva_pkg::OP_UGE:     value_next = bva_pkg::RESULT_BITS'(!ult);
            bva_pkg::OP_SLT:     value_next = bva_pkg::RESULT_BITS'(slt);
            bva_pkg::OP_SLE:     value_next = bva_pkg::RESULT_BITS'(!sgt);
            bva_pkg::OP_SGT:     value_next = bva_pkg::RESULT_BITS'(sgt);
            bva_pkg::OP_SGE:     value_next = bva_pkg::RESULT_BITS'(!slt);
            bva_pkg::OP_ADD: begin
                value_next = bva_pkg::RESULT_BITS'(sum2_reg);
                width_next = bva_pkg::RWIDTH_BITS'(ws2_reg);
            end
            bva_pkg::OP_SUB: begin
                value_next = bva_pkg::RESULT_BITS'(dif2_reg);
                width_next = bva_pkg::RWIDTH_BITS'(ws2_reg);
            end
            default: begin
                value_next = '0;
                width_next = bva_pkg::RWIDTH_BITS'(wmax2_reg);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv3) begin
            v3_reg <= v2_reg;
        end
        if (adv3 && v2_reg) begin
            value_reg <= value_next;
            width_reg <= width_next;
            bad_reg   <= bad_next;
        end
    end

    assign m_valid        = v3_reg;
    assign m_result_value = value_reg;
    assign m_result_width = width_reg;
    assign m_bad_request  = bad_reg;

endmodule
